@@ src/cif_pkg.sv @@
// shared constants, codes and beat types of the can identifier ignore filter
package cif_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int ID_W       = 11;
	localparam int ID_MAX     = 'h7ff;

	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;
	localparam int LC_W   = (CNT_W > 5) ? CNT_W : 5;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE = 2'd2;
	localparam logic [1:0] ST_NO_INDEX  = 2'd3;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] id_value;
		logic [3:0]  entry_index;
	} req_item_t;

	typedef struct packed {
		logic [1:0]      status;
		logic            ignored;
		logic [ID_W-1:0] entry_id;
		logic [4:0]      list_count;
	} rsp_item_t;

	// count reported modulo 32
	function automatic logic [4:0] to_list_count(cnt_t c);
		logic [LC_W-1:0] w;
		w = LC_W'(c);
		return w[4:0];
	endfunction

endpackage

@@ src/can_id_ignore_filter.sv @@
// can identifier ignore list: add, clear, check and read over one id memory
//
// One request beat is taken at a time and gives exactly one response beat. Add and clear pass
// from acceptance through S_FIN to the response register, read through S_RDW and S_FIN, and
// check through S_WALK, S_DRAIN and S_FIN (straight to S_FIN when the list is empty), because
// the check walks the stored identifiers one per cycle through the single read port of the id
// memory. The response sits in its own register, so the next request is taken while an earlier
// response still waits. The id memory has no reset; only entries below the count are ever used.
module can_id_ignore_filter
	import cif_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_RDW   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]      state_q;
	cnt_t            count_q;
	addr_t           ptr_q;
	logic [15:0]     id_q;
	logic            hit_q;
	logic            cmp_s1;
	rsp_item_t       res_q;
	rsp_item_t       out_q;
	logic            out_valid_q;

	logic [ID_W-1:0] mem [LIST_DEPTH];
	logic [ID_W-1:0] rd_data_q;
	addr_t           rd_addr;
	logic            mem_we;
	logic [CMP_W-1:0] idx_w;
	logic            id_small;
	logic            match;
	logic            walk_last;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign idx_w     = CMP_W'(req.entry_index);
	assign id_small  = (req.id_value <= 16'(ID_MAX));
	assign rd_addr   = (state_q == S_WALK) ? ptr_q : idx_w[ADDR_W-1:0];
	assign mem_we    = req_valid && req_ready && (req.opcode == OP_ADD)
	                   && (count_q < CNT_W'(LIST_DEPTH)) && id_small;
	// an id wider than 11 bits can never match a stored entry
	assign match     = cmp_s1 && (rd_data_q == id_q[ID_W-1:0])
	                   && (id_q <= 16'(ID_MAX));
	assign walk_last = (CNT_W'(ptr_q) == (count_q - CNT_W'(1)));

	// one item in flight at a time, so no read that is used can overlap a write to the same entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[ADDR_W-1:0]] <= req.id_value[ID_W-1:0];
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			cmp_s1      <= 1'b0;
			hit_q       <= 1'b0;
			ptr_q       <= '0;
		end else begin
			if ((state_q == S_FIN) && (!out_valid_q || rsp_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			// compare runs on the registered read data, in the cycle after each walk read
			cmp_s1 <= (state_q == S_WALK);
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						id_q           <= req.id_value;
						res_q.ignored  <= 1'b0;
						res_q.entry_id <= '0;
						case (req.opcode)
							OP_ADD: begin
								state_q <= S_FIN;
								if (count_q >= CNT_W'(LIST_DEPTH)) begin
									res_q.status     <= ST_FULL;
									res_q.list_count <= to_list_count(count_q);
								end else if (!id_small) begin
									res_q.status     <= ST_TOO_LARGE;
									res_q.list_count <= to_list_count(count_q);
								end else begin
									res_q.status     <= ST_OK;
									count_q          <= count_q + CNT_W'(1);
									res_q.list_count <= to_list_count(count_q + CNT_W'(1));
								end
							end
							OP_CLEAR: begin
								state_q          <= S_FIN;
								res_q.status     <= ST_OK;
								count_q          <= '0;
								res_q.list_count <= 5'd0;
							end
							OP_CHECK: begin
								res_q.status     <= ST_OK;
								res_q.list_count <= to_list_count(count_q);
								hit_q            <= 1'b0;
								ptr_q            <= '0;
								if (count_q != '0) begin
									state_q <= S_WALK;
								end else begin
									state_q <= S_FIN;
								end
							end
							OP_READ: begin
								res_q.list_count <= to_list_count(count_q);
								if (idx_w < CMP_W'(count_q)) begin
									res_q.status <= ST_OK;
									state_q      <= S_RDW;
								end else begin
									res_q.status <= ST_NO_INDEX;
									state_q      <= S_FIN;
								end
							end
							default: begin
								res_q.status     <= ST_OK;
								res_q.list_count <= to_list_count(count_q);
								state_q          <= S_FIN;
							end
						endcase
					end
				end
				S_WALK: begin
					// issue one read per cycle, compare the previous one
					if (match) begin
						hit_q <= 1'b1;
					end
					ptr_q <= ptr_q + ADDR_W'(1);
					if (walk_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					res_q.ignored <= hit_q | match;
					state_q       <= S_FIN;
				end
				S_RDW: begin
					res_q.entry_id <= rd_data_q;
					state_q        <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || rsp_ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ test/cif_checker.sv @@
// checker for the can identifier ignore filter: predicts each response beat and compares it
module cif_checker
	import cif_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_item_t req,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_item_t rsp,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [ID_W-1:0] id_list [LIST_DEPTH];
	int              held_count;
	rsp_item_t       outcome_q [$];
	rsp_item_t       want;

	// updates the shadow list and returns the response the request should give
	function automatic rsp_item_t filter_outcome(req_item_t r);
		rsp_item_t o;
		o = '0;
		o.status = ST_OK;
		case (r.opcode)
			OP_ADD: begin
				// fullness wins over an oversized identifier
				if (held_count >= LIST_DEPTH)
					o.status = ST_FULL;
				else if (r.id_value > ID_MAX)
					o.status = ST_TOO_LARGE;
				else begin
					id_list[held_count] = r.id_value[ID_W-1:0];
					held_count++;
				end
			end
			OP_CLEAR: begin
				held_count = 0;
			end
			OP_CHECK: begin
				for (int i = 0; i < held_count; i++)
					if (16'(id_list[i]) == r.id_value)
						o.ignored = 1'b1;
			end
			default: begin
				if (int'(r.entry_index) < held_count && int'(r.entry_index) < LIST_DEPTH)
					o.entry_id = id_list[r.entry_index];
				else
					o.status = ST_NO_INDEX;
			end
		endcase
		o.list_count = 5'(held_count);
		return o;
	endfunction

	task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			outcome_q.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (outcome_q.size() == 0) begin
					$error("response beat with no request outstanding");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("ignored", want.ignored, rsp.ignored);
					check_field("entry_id", want.entry_id, rsp.entry_id);
					check_field("list_count", want.list_count, rsp.list_count);
				end
			end
			if (req_valid && req_ready)
				outcome_q.push_back(filter_outcome(req));
			pending = outcome_q.size();
		end
	end

endmodule

@@ test/tb_can_id_ignore_filter.sv @@
// testbench top for the can identifier ignore filter: stimulus, flow control and verdict
module tb_can_id_ignore_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import cif_pkg::*;

	localparam int ITEM_TARGET  = 1700;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD    = 300;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	int fail_count;
	int pending;
	int sent;
	int idle_cycles;
	int snd_gap_max;
	int rsp_gap_max;
	int rsp_beats;
	logic [ID_W-1:0] seq_ids [$];

	can_id_ignore_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	cif_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// present one request beat after a random gap and hold it until taken
	task automatic send_item(logic [1:0] op, logic [15:0] id, logic [3:0] idx);
		int gap;
		gap = $urandom_range(0, snd_gap_max);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.opcode      = op;
		req.id_value    = id;
		req.entry_index = idx;
		req_valid       = 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		sent++;
	endtask

	// mostly legal ids, some oversized, some repeats of ids already added
	function automatic logic [15:0] pick_id();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 2)
			return 16'($urandom);
		else if (roll < 4 && seq_ids.size() > 0)
			return 16'(seq_ids[$urandom_range(0, seq_ids.size() - 1)]);
		else if (roll == 4 && seq_ids.size() > 0)
			return {5'b00001, seq_ids[$urandom_range(0, seq_ids.size() - 1)]};
		else
			return 16'($urandom_range(0, ID_MAX));
	endfunction

	// response side: random stalls, plus two long hold-offs to back the block up
	initial begin
		int gap;
		rsp_beats = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, rsp_gap_max);
			if (rsp_beats == 150 || rsp_beats == 900)
				gap = LONG_HOLD;
			if (gap > 0) begin
				rsp_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready = 1'b1;
			do @(posedge clk); while (!rsp_valid);
			rsp_beats++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] id;
		int n;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_ready   = 1'b0;
		sent        = 0;
		idle_cycles = 0;
		snd_gap_max = 18;
		rsp_gap_max = 18;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, id extremes, oversized ids, aliasing above 11 bits
		send_item(OP_READ, 16'h0000, 4'hf);
		send_item(OP_CHECK, 16'h0000, 4'h0);
		send_item(OP_ADD, 16'h0000, 4'h0);
		send_item(OP_ADD, 16'h07ff, 4'hf);
		send_item(OP_ADD, 16'h0800, 4'h0);
		send_item(OP_ADD, 16'hffff, 4'hf);
		send_item(OP_CHECK, 16'h07ff, 4'h0);
		send_item(OP_CHECK, 16'h0800, 4'h0);
		send_item(OP_CHECK, 16'hffff, 4'hf);
		send_item(OP_CHECK, 16'h0000, 4'h0);
		send_item(OP_READ, 16'hffff, 4'h0);
		send_item(OP_READ, 16'h0000, 4'h1);
		send_item(OP_READ, 16'h0000, 4'h2);
		send_item(OP_READ, 16'h0000, 4'hf);
		send_item(OP_CLEAR, 16'hffff, 4'hf);
		send_item(OP_READ, 16'h0000, 4'h0);
		send_item(OP_CHECK, 16'h07ff, 4'h0);
		send_item(OP_CLEAR, 16'h0000, 4'h0);

		while (sent < ITEM_TARGET) begin
			snd_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
			rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
			if ($urandom_range(0, 9) < 7) begin
				// clear, fill to a random depth (sometimes past full), then query
				seq_ids.delete();
				send_item(OP_CLEAR, 16'($urandom), 4'($urandom));
				n = $urandom_range(0, 20);
				repeat (n) begin
					id = pick_id();
					send_item(OP_ADD, id, 4'($urandom));
					if (id <= ID_MAX && seq_ids.size() < LIST_DEPTH)
						seq_ids.push_back(id[ID_W-1:0]);
				end
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 2) == 0)
						send_item(OP_READ, 16'($urandom), 4'($urandom));
					else
						send_item(OP_CHECK, pick_id(), 4'($urandom));
				end
			end else begin
				repeat ($urandom_range(1, 12))
					send_item(2'($urandom), 16'($urandom), 4'($urandom));
			end
		end
		req_valid = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
